// ----- hw/rtl/lobm_pkg.sv -----
`timescale 1ns / 1ps
package lobm_pkg;
   localparam int BOOK_DEPTH = 16;

   localparam logic [2:0] ST_RESTED = 3'd0;
   localparam logic [2:0] ST_FILLED = 3'd1;
   localparam logic [2:0] ST_MKT_DROP = 3'd2;
   localparam logic [2:0] ST_FULL_DROP = 3'd3;
   localparam logic [2:0] ST_NO_ACTION = 3'd4;

   typedef struct packed {
      logic [31:0] price;
      logic [31:0] qty;
      logic [31:0] order;
      logic [15:0] trader;
   } entry_type;

   // per-cycle command broadcast to every cell of one side
   typedef struct packed {
      logic      pop;      // shift toward the head
      logic      dec;      // head quantity decrements
      logic [31:0] dec_qty;
      logic      ins;      // insert new entry
      logic      is_bid;
      entry_type new_entry;
   } cell_cmd_type;
endpackage

// ----- hw/rtl/lobm_cell.sv -----
`timescale 1ns / 1ps
module lobm_cell (
   input  logic                     clock,
   input  lobm_pkg::cell_cmd_type   cmd,
   input  logic                     is_head,
   input  logic                     valid_here,
   input  logic                     valid_prev,
   input  logic                     ahead_prev,
   input  lobm_pkg::entry_type      prev_entry,
   input  lobm_pkg::entry_type      next_entry,
   output lobm_pkg::entry_type      entry,
   output logic                     ahead
);
   lobm_pkg::entry_type entry_ff, entry_in;
   logic take_new;

   // entry ranks at or ahead of the new price
   assign ahead = valid_here && (cmd.is_bid ? (entry_ff.price >= cmd.new_entry.price)
                                            : (entry_ff.price <= cmd.new_entry.price));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      take_new = !ahead && (is_head || (valid_prev && ahead_prev));
      if (cmd.pop) begin
         entry_in = next_entry;
      end else if (cmd.dec && is_head) begin
         entry_in.qty = entry_ff.qty - cmd.dec_qty;
      end else if (cmd.ins) begin
         if (take_new) begin
            entry_in = cmd.new_entry;
         end else if (!ahead && !is_head && !(valid_prev && ahead_prev)) begin
            entry_in = prev_entry;
         end else if (!ahead && is_head) begin
            entry_in = cmd.new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
endmodule

// ----- hw/rtl/lobm_side.sv -----
`timescale 1ns / 1ps
module lobm_side #(
   parameter int DEPTH = lobm_pkg::BOOK_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lobm_pkg::cell_cmd_type cmd,
   output lobm_pkg::entry_type    head,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int CW = $clog2(DEPTH + 1);
   lobm_pkg::entry_type ents [DEPTH];
   logic [DEPTH-1:0] ahead;
   logic [DEPTH-1:0] vld;
   logic [CW-1:0] count_ff, count_in;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign vld[i] = (CW'(i) < count_ff);
      lobm_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .is_head    (i == 0),
         .valid_here (vld[i]),
         .valid_prev (i == 0 ? 1'b0 : vld[(i == 0) ? 0 : i - 1]),
         .ahead_prev (i == 0 ? 1'b0 : ahead[(i == 0) ? 0 : i - 1]),
         .prev_entry (ents[(i == 0) ? 0 : i - 1]),
         .next_entry (ents[(i == DEPTH - 1) ? i : i + 1]),
         .entry      (ents[i]),
         .ahead      (ahead[i])
      );
   end

   assign head = ents[0];
   assign count = count_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.pop) count_in = count_ff - CW'(1);
      else if (cmd.ins) count_in = count_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

// ----- hw/rtl/limit_order_book_matcher.sv -----
`timescale 1ns / 1ps
// Price-time priority limit order book matcher.
// Input channel req_*: one order per transfer (side, kind, limit price,
// quantity, prior filled, order id, trader id). Accepted when req_valid
// is high and req_stall is low; the block takes one order at a time.
// Result channel rsp_*: zero or more trade items followed by one status
// item with rsp_last set. Each item is held while rsp_stall is high.
// Each side of the book is a row of cells, best entry at the head. All
// cells shift up on removal; cells behind a new entry shift on insertion.
// An order with nothing to do has its status item registered at the
// accepting edge. Otherwise the order enters the match state, where each
// trade is registered while the output is free; the opposite side is
// updated with each trade, and a remainder that rests is inserted as the
// status item is issued. An order makes at most BOOK_DEPTH trades. A new
// order is taken once the status item has been transferred and the block
// is back in idle.
// Reset (synchronous, active high) empties both sides and clears the
// trade counter. A stall on the result side freezes matching until the
// held item is taken.
module limit_order_book_matcher #(
   parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_side,
   input  logic        req_kind,
   input  logic [31:0] req_limit_price,
   input  logic [31:0] req_order_qty,
   input  logic [31:0] req_prior_filled,
   input  logic [31:0] req_order_ref,
   input  logic [15:0] req_trader_ref,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_trade,
   output logic [31:0] rsp_trade_seq,
   output logic [31:0] rsp_buy_ref,
   output logic [31:0] rsp_sell_ref,
   output logic [15:0] rsp_buy_trader,
   output logic [15:0] rsp_sell_trader,
   output logic [31:0] rsp_trade_price,
   output logic [31:0] rsp_trade_qty,
   output logic [2:0]  rsp_order_state,
   output logic        rsp_last
);
   localparam int CW = $clog2(BOOK_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_MATCH, S_WAIT} state_type;
   state_type state_ff;

   logic        sell_ff, mkt_ff;
   logic [31:0] lim_ff, rem_ff, oref_ff, seq_ff;
   logic [15:0] otr_ff;

   lobm_pkg::cell_cmd_type bid_cmd, ask_cmd, opp_cmd, own_cmd;
   lobm_pkg::entry_type bid_head, ask_head, opp_head;
   logic [CW-1:0] bid_count, ask_count, opp_count, own_count;

   lobm_side #(.DEPTH(BOOK_DEPTH)) u_bid (
      .clock(clock), .reset(reset), .cmd(bid_cmd), .head(bid_head), .count(bid_count));
   lobm_side #(.DEPTH(BOOK_DEPTH)) u_ask (
      .clock(clock), .reset(reset), .cmd(ask_cmd), .head(ask_head), .count(ask_count));

   assign opp_head  = sell_ff ? bid_head : ask_head;
   assign opp_count = sell_ff ? bid_count : ask_count;
   assign own_count = sell_ff ? ask_count : bid_count;

   logic out_free, crosses, do_trade, do_status;
   logic [31:0] q, px;
   logic [2:0] st;

   assign out_free = !rsp_valid || !rsp_stall;
   assign crosses = mkt_ff || (sell_ff ? (lim_ff <= opp_head.price)
                                       : (lim_ff >= opp_head.price));
   assign q  = (rem_ff < opp_head.qty) ? rem_ff : opp_head.qty;
   assign px = mkt_ff ? opp_head.price
                      : ((lim_ff < opp_head.price) ? lim_ff : opp_head.price);
   assign do_trade  = (state_ff == S_MATCH) && out_free && rem_ff != 0
                      && opp_count != 0 && crosses;
   assign do_status = (state_ff == S_MATCH) && out_free && !do_trade;

   always_comb begin
      if (rem_ff == 0) st = lobm_pkg::ST_FILLED;
      else if (mkt_ff) st = lobm_pkg::ST_MKT_DROP;
      else if (own_count >= CW'(BOOK_DEPTH)) st = lobm_pkg::ST_FULL_DROP;
      else st = lobm_pkg::ST_RESTED;
   end

   always_comb begin
      opp_cmd = '0;
      own_cmd = '0;
      opp_cmd.is_bid = sell_ff;
      own_cmd.is_bid = !sell_ff;
      own_cmd.new_entry.price  = lim_ff;
      own_cmd.new_entry.qty    = rem_ff;
      own_cmd.new_entry.order  = oref_ff;
      own_cmd.new_entry.trader = otr_ff;
      opp_cmd.new_entry = own_cmd.new_entry;
      if (do_trade) begin
         opp_cmd.dec = 1'b1;
         opp_cmd.dec_qty = q;
         opp_cmd.pop = (opp_head.qty == q);
      end
      if (do_status && st == lobm_pkg::ST_RESTED) own_cmd.ins = 1'b1;
      bid_cmd = sell_ff ? opp_cmd : own_cmd;
      ask_cmd = sell_ff ? own_cmd : opp_cmd;
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
         seq_ff    <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  sell_ff <= req_side;
                  mkt_ff  <= req_kind;
                  lim_ff  <= req_limit_price;
                  oref_ff <= req_order_ref;
                  otr_ff  <= req_trader_ref;
                  if (req_order_qty == 0 || req_prior_filled >= req_order_qty) begin
                     rsp_valid       <= 1'b1;
                     rsp_is_trade    <= 1'b0;
                     rsp_trade_seq   <= '0;
                     rsp_buy_ref     <= '0;
                     rsp_sell_ref    <= '0;
                     rsp_buy_trader  <= '0;
                     rsp_sell_trader <= '0;
                     rsp_trade_price <= '0;
                     rsp_trade_qty   <= '0;
                     rsp_order_state <= lobm_pkg::ST_NO_ACTION;
                     rsp_last        <= 1'b1;
                     state_ff        <= S_WAIT;
                  end else begin
                     rem_ff   <= req_order_qty - req_prior_filled;
                     state_ff <= S_MATCH;
                  end
               end
            end
            S_MATCH: begin
               if (do_trade) begin
                  rsp_valid       <= 1'b1;
                  rsp_is_trade    <= 1'b1;
                  rsp_trade_seq   <= seq_ff;
                  rsp_buy_ref     <= sell_ff ? opp_head.order : oref_ff;
                  rsp_sell_ref    <= sell_ff ? oref_ff : opp_head.order;
                  rsp_buy_trader  <= sell_ff ? opp_head.trader : otr_ff;
                  rsp_sell_trader <= sell_ff ? otr_ff : opp_head.trader;
                  rsp_trade_price <= px;
                  rsp_trade_qty   <= q;
                  rsp_order_state <= lobm_pkg::ST_RESTED;
                  rsp_last        <= 1'b0;
                  seq_ff          <= seq_ff + 32'd1;
                  rem_ff          <= rem_ff - q;
               end else if (do_status) begin
                  rsp_valid       <= 1'b1;
                  rsp_is_trade    <= 1'b0;
                  rsp_trade_seq   <= '0;
                  rsp_buy_ref     <= '0;
                  rsp_sell_ref    <= '0;
                  rsp_buy_trader  <= '0;
                  rsp_sell_trader <= '0;
                  rsp_trade_price <= '0;
                  rsp_trade_qty   <= '0;
                  rsp_order_state <= st;
                  rsp_last        <= 1'b1;
                  state_ff        <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: begin
               rsp_valid <= 1'b0;
               state_ff  <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !(req_valid && !req_stall))
      else $error("second order taken while busy");
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !rsp_is_trade)
      else $error("last item is a trade");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      bid_count <= CW'(BOOK_DEPTH) && ask_count <= CW'(BOOK_DEPTH))
      else $error("book count overflow");
`endif
endmodule
